FILE: design/tekd_pkg.sv
// ----------------------------------------------------------------------------
// tekd_pkg
// Shared types and constants for the terminal escape key decoder.
// ----------------------------------------------------------------------------
package tekd_pkg;

  // Longest CSI buffer; at most MAX_SEQ-2 bytes may follow '['
  localparam int MAX_SEQ = 16;
  localparam int CNT_W   = 6;
  localparam logic [CNT_W-1:0] SEQ_LIMIT = CNT_W'(MAX_SEQ - 2);

  // Parser phases
  localparam logic [1:0] PH_GROUND = 2'd0;
  localparam logic [1:0] PH_ESC    = 2'd1;
  localparam logic [1:0] PH_CSI    = 2'd2;

  // Key codes
  localparam logic [3:0] K_PLAIN = 4'd0;
  localparam logic [3:0] K_ESC   = 4'd1;
  localparam logic [3:0] K_UP    = 4'd2;
  localparam logic [3:0] K_DOWN  = 4'd3;
  localparam logic [3:0] K_RIGHT = 4'd4;
  localparam logic [3:0] K_LEFT  = 4'd5;
  localparam logic [3:0] K_HOME  = 4'd6;
  localparam logic [3:0] K_END   = 4'd7;
  localparam logic [3:0] K_DEL   = 4'd8;
  localparam logic [3:0] K_PGUP  = 4'd9;
  localparam logic [3:0] K_PGDN  = 4'd10;

  // Action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_IDLE = 1'b1;

  // Characters
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UC    = 8'h43;
  localparam logic [7:0] CH_UD    = 8'h44;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UH    = 8'h48;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } byte_item_t;

  typedef struct packed {
    logic [3:0] key_kind;
    logic       shifted;
    logic [7:0] plain_byte;
  } key_item_t;

endpackage

FILE: design/terminal_escape_key_decoder.sv
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder
// Decodes terminal bytes and idle events into plain keys and CSI key codes.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel (byte_valid/byte_stall/byte_item) carries one word per
//   received byte or idle timeout. key channel (key_valid/key_stall/key_item)
//   returns zero or one key word per input word, in order.
//   A word accepted into the input register moves on into the result
//   register, where its key word, if any, is valid. One word is taken
//   every cycle while the key side drains; the parser state updates in the
//   same cycle the input register moves into the result register.
//   Reset (rst, synchronous) empties both registers and returns the parser to
//   ground with an empty sequence.
//   When key_stall holds a pending key word, the input register holds too,
//   and byte_stall rises once that register is full. A word that yields no
//   key still waits for the result register to be free.
// ----------------------------------------------------------------------------
module terminal_escape_key_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  tekd_pkg::byte_item_t byte_item,
  output logic                 key_valid,
  input  logic                 key_stall,
  output tekd_pkg::key_item_t  key_item
);

  // Input register
  logic                 in_full;
  tekd_pkg::byte_item_t in_q;
  logic                 adv;

  // Parser state
  logic [1:0]                 phase, phase_next;
  logic [tekd_pkg::CNT_W-1:0] seq_count, seq_count_next;
  logic [7:0]                 first_param, first_param_next;
  logic                       semi_seen, semi_seen_next;
  logic                       await_digit, await_digit_next;
  logic [3:0]                 mod_digit, mod_digit_next;

  // Decode results
  logic                      emit;
  tekd_pkg::key_item_t       res;
  logic [7:0]                b;
  logic                      idle;
  logic [tekd_pkg::CNT_W-1:0] cnt_inc;
  logic                      is_final;
  logic                      is_digit;
  logic                      sh;
  logic [3:0]                fin_kind;
  logic                      fin_sh;

  assign adv        = in_full && (!key_valid || !key_stall);
  assign byte_stall = in_full && key_valid && key_stall;

  assign b       = in_q.data_byte;
  assign idle    = (in_q.action == tekd_pkg::ACT_IDLE);
  assign cnt_inc = seq_count + tekd_pkg::CNT_W'(1);
  assign is_final = (b inside {[tekd_pkg::CH_UA:tekd_pkg::CH_UZ],
                               [tekd_pkg::CH_LA:tekd_pkg::CH_LZ],
                               tekd_pkg::CH_TILDE});
  assign is_digit = (b inside {[tekd_pkg::CH_0:tekd_pkg::CH_9]});

  // Sequence bookkeeping for a byte inside CSI
  always_comb begin
    first_param_next = (seq_count == '0) ? b : first_param;
    semi_seen_next   = semi_seen;
    await_digit_next = await_digit;
    mod_digit_next   = mod_digit;
    if (await_digit) begin
      await_digit_next = 1'b0;
      if (is_digit) begin
        mod_digit_next = 4'(b - tekd_pkg::CH_0);
      end
    end else if (b == tekd_pkg::CH_SEMI && !semi_seen) begin
      semi_seen_next   = 1'b1;
      await_digit_next = 1'b1;
    end
  end

  // Map the final byte to a key
  assign sh = semi_seen_next && (mod_digit_next == 4'd2);

  always_comb begin
    fin_sh = 1'b0;
    case (b)
      tekd_pkg::CH_UA: begin fin_kind = tekd_pkg::K_UP;    fin_sh = sh; end
      tekd_pkg::CH_UB: begin fin_kind = tekd_pkg::K_DOWN;  fin_sh = sh; end
      tekd_pkg::CH_UC: begin fin_kind = tekd_pkg::K_RIGHT; fin_sh = sh; end
      tekd_pkg::CH_UD: begin fin_kind = tekd_pkg::K_LEFT;  fin_sh = sh; end
      tekd_pkg::CH_UH: begin fin_kind = tekd_pkg::K_HOME;  fin_sh = sh; end
      tekd_pkg::CH_UF: begin fin_kind = tekd_pkg::K_END;   fin_sh = sh; end
      tekd_pkg::CH_TILDE: begin
        case (first_param_next)
          tekd_pkg::CH_1: fin_kind = tekd_pkg::K_HOME;
          tekd_pkg::CH_3: fin_kind = tekd_pkg::K_DEL;
          tekd_pkg::CH_4: fin_kind = tekd_pkg::K_END;
          tekd_pkg::CH_5: fin_kind = tekd_pkg::K_PGUP;
          tekd_pkg::CH_6: fin_kind = tekd_pkg::K_PGDN;
          default:        fin_kind = tekd_pkg::K_ESC;
        endcase
      end
      default: fin_kind = tekd_pkg::K_ESC;
    endcase
  end

  // Next state and result for the word in the input register
  always_comb begin
    phase_next          = tekd_pkg::PH_GROUND;
    seq_count_next      = '0;
    emit                = 1'b0;
    res.key_kind        = tekd_pkg::K_ESC;
    res.shifted         = 1'b0;
    res.plain_byte      = 8'd0;
    case (phase)
      tekd_pkg::PH_ESC: begin
        if (!idle && b == tekd_pkg::CH_LBRK) begin
          phase_next = tekd_pkg::PH_CSI;
        end else begin
          emit = 1'b1;
        end
      end
      tekd_pkg::PH_CSI: begin
        if (idle) begin
          emit = 1'b1;
        end else if (is_final) begin
          emit         = 1'b1;
          res.key_kind = fin_kind;
          res.shifted  = fin_sh;
        end else if (cnt_inc >= tekd_pkg::SEQ_LIMIT) begin
          emit = 1'b1;
        end else begin
          phase_next     = tekd_pkg::PH_CSI;
          seq_count_next = cnt_inc;
        end
      end
      default: begin
        if (!idle) begin
          if (b == tekd_pkg::CH_ESC) begin
            phase_next = tekd_pkg::PH_ESC;
          end else begin
            emit           = 1'b1;
            res.key_kind   = tekd_pkg::K_PLAIN;
            res.plain_byte = b;
          end
        end
      end
    endcase
  end

  // Capture input words
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_q <= byte_item;
    end
  end

  // Advance parser state; sequence fields live only while inside CSI
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= tekd_pkg::PH_GROUND;
      seq_count   <= '0;
      first_param <= 8'd0;
      semi_seen   <= 1'b0;
      await_digit <= 1'b0;
      mod_digit   <= 4'd0;
    end else if (adv) begin
      phase     <= phase_next;
      seq_count <= seq_count_next;
      if (phase == tekd_pkg::PH_CSI && phase_next == tekd_pkg::PH_CSI) begin
        first_param <= first_param_next;
        semi_seen   <= semi_seen_next;
        await_digit <= await_digit_next;
        mod_digit   <= mod_digit_next;
      end else begin
        first_param <= 8'd0;
        semi_seen   <= 1'b0;
        await_digit <= 1'b0;
        mod_digit   <= 4'd0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (adv) begin
      key_valid <= emit;
    end else if (key_valid && !key_stall) begin
      key_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key_item <= res;
    end
  end

  // Checks
  a_plain_only: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_item.key_kind != tekd_pkg::K_PLAIN |-> key_item.plain_byte == 8'd0)
    else $error("plain_byte set on a non-plain key");

  a_shift_kind: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_item.shifted |->
      (key_item.key_kind >= tekd_pkg::K_UP && key_item.key_kind <= tekd_pkg::K_END))
    else $error("shift on a key that cannot be shifted");

  a_ground_clean: assert property (@(posedge clk) disable iff (rst)
    phase != tekd_pkg::PH_CSI |->
      seq_count == '0 && !semi_seen && !await_digit && mod_digit == 4'd0)
    else $error("sequence state left over outside CSI");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    seq_count < tekd_pkg::SEQ_LIMIT)
    else $error("sequence count passed the buffer limit");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_full && key_valid && key_stall |=> in_full && $stable(in_q))
    else $error("input word lost while the result is stalled");

endmodule

FILE: tb/tb_terminal_escape_key_decoder.sv
// ----------------------------------------------------------------------------
// tb_terminal_escape_key_decoder
// Self-checking bench for the terminal escape key decoder. A short table of
// byte and idle words covers plain bytes at both extremes, lone and broken
// ESC, cursor, tilde and unknown sequences. Random CSI sequences and line
// noise follow. The table gives the key words it expects; a behavioral
// decoder in the bench predicts the rest, and the monitor compares each
// accepted key word field by field. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_terminal_escape_key_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 1650;
  localparam int CALM_ITEMS  = 200;
  localparam int MAX_SHOWN   = 10;
  localparam real RUN_LIMIT_NS = 5_000_000.0;

  // Digit after the first ';' that marks a shifted key
  localparam logic [3:0]          SHIFT_MOD = 4'd2;
  localparam logic [7:0]          CH_2      = tekd_pkg::CH_1 + 8'd1;
  localparam tekd_pkg::key_item_t NO_KEY    = '0;

  localparam logic [7:0] CURSOR_FINALS [6] = '{tekd_pkg::CH_UA, tekd_pkg::CH_UB,
                                               tekd_pkg::CH_UC, tekd_pkg::CH_UD,
                                               tekd_pkg::CH_UH, tekd_pkg::CH_UF};
  localparam logic [7:0] TILDE_PARAMS  [5] = '{tekd_pkg::CH_1, tekd_pkg::CH_3,
                                               tekd_pkg::CH_4, tekd_pkg::CH_5,
                                               tekd_pkg::CH_6};

  // One row of the directed table; key is checked only where known is set
  typedef struct packed {
    logic                action;
    logic [7:0]          data;
    logic                known;
    tekd_pkg::key_item_t key;
  } step_t;

  localparam int PLAN_LEN = 27;
  localparam step_t PLAN [PLAN_LEN] = '{
    {tekd_pkg::ACT_IDLE, 8'h00, 1'b0, NO_KEY},                // idle at ground: nothing
    {tekd_pkg::ACT_BYTE, 8'h00, 1'b1, tekd_pkg::K_PLAIN, 1'b0, 8'h00},
    {tekd_pkg::ACT_BYTE, 8'hFF, 1'b1, tekd_pkg::K_PLAIN, 1'b0, 8'hFF},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_ESC, 1'b0, NO_KEY},     // lone ESC, then idle
    {tekd_pkg::ACT_IDLE, 8'hFF, 1'b1, tekd_pkg::K_ESC, 1'b0, 8'h00},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_ESC, 1'b0, NO_KEY},     // ESC, byte dropped
    {tekd_pkg::ACT_BYTE, 8'hFF, 1'b1, tekd_pkg::K_ESC, 1'b0, 8'h00},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_ESC, 1'b0, NO_KEY},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_LBRK, 1'b0, NO_KEY},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_UA, 1'b1, tekd_pkg::K_UP, 1'b0, 8'h00},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_ESC, 1'b0, NO_KEY},     // shifted home
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_LBRK, 1'b0, NO_KEY},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_1, 1'b0, NO_KEY},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_SEMI, 1'b0, NO_KEY},
    {tekd_pkg::ACT_BYTE, CH_2, 1'b0, NO_KEY},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_UH, 1'b1, tekd_pkg::K_HOME, 1'b1, 8'h00},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_ESC, 1'b0, NO_KEY},     // page down
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_LBRK, 1'b0, NO_KEY},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_6, 1'b0, NO_KEY},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_TILDE, 1'b1, tekd_pkg::K_PGDN, 1'b0, 8'h00},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_ESC, 1'b0, NO_KEY},     // idle inside sequence
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_LBRK, 1'b0, NO_KEY},
    {tekd_pkg::ACT_IDLE, 8'h00, 1'b1, tekd_pkg::K_ESC, 1'b0, 8'h00},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_ESC, 1'b0, NO_KEY},     // ESC inside, unknown final
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_LBRK, 1'b0, NO_KEY},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_ESC, 1'b0, NO_KEY},
    {tekd_pkg::ACT_BYTE, tekd_pkg::CH_LZ, 1'b1, tekd_pkg::K_ESC, 1'b0, 8'h00}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 byte_valid = 1'b0;
  logic                 byte_stall;
  tekd_pkg::byte_item_t byte_item = '0;
  logic                 key_valid;
  logic                 key_stall = 1'b0;
  tekd_pkg::key_item_t  key_item;

  // Decoder state mirrored by the bench
  logic [1:0]                 phase;
  logic [tekd_pkg::CNT_W-1:0] seq_cnt;
  logic [7:0]                 first_prm;
  logic                       semi_seen;
  logic                       want_digit;
  logic [3:0]                 mod_digit;

  tekd_pkg::key_item_t expected_keys[$];
  int        sent_items = 0;
  int        bad_count  = 0;
  int        tx_odds    = 0;
  int        rx_odds    = 0;
  int        stall_left = 0;
  bit        calm       = 1'b0;

  terminal_escape_key_decoder DUT (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .key_valid  (key_valid),
    .key_stall  (key_stall),
    .key_item   (key_item)
  );

  always #5 clk = ~clk;

  function automatic bit ends_seq(input logic [7:0] b);
    return (b >= tekd_pkg::CH_UA && b <= tekd_pkg::CH_UZ) ||
           (b >= tekd_pkg::CH_LA && b <= tekd_pkg::CH_LZ) || b == tekd_pkg::CH_TILDE;
  endfunction

  // Random byte that keeps a sequence open
  function automatic logic [7:0] mid_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while (ends_seq(b)) b = 8'($urandom);
    return b;
  endfunction

  // Byte after ';': mostly the shift digit, else another digit or junk
  function automatic logic [7:0] mod_byte();
    case ($urandom_range(0, 3))
      0, 1:    return CH_2;
      2:       return tekd_pkg::CH_0 + 8'($urandom_range(0, 9));
      default: return mid_byte();
    endcase
  endfunction

  task automatic clear_parse();
    phase      = tekd_pkg::PH_GROUND;
    seq_cnt    = '0;
    first_prm  = '0;
    semi_seen  = 1'b0;
    want_digit = 1'b0;
    mod_digit  = '0;
  endtask

  // Advance the mirrored decoder by one word; return the key it yields
  task automatic decode_word(input tekd_pkg::byte_item_t w, output bit got,
                             output tekd_pkg::key_item_t k);
    logic [7:0] b;
    logic [3:0] kind;
    logic       sh;
    b   = w.data_byte;
    got = 1'b0;
    k   = NO_KEY;
    if (phase == tekd_pkg::PH_ESC) begin
      if (w.action == tekd_pkg::ACT_BYTE && b == tekd_pkg::CH_LBRK) begin
        phase   = tekd_pkg::PH_CSI;
        seq_cnt = '0;
      end else begin
        clear_parse();
        got = 1'b1;
        k.key_kind = tekd_pkg::K_ESC;
      end
    end else if (phase == tekd_pkg::PH_CSI) begin
      if (w.action == tekd_pkg::ACT_IDLE) begin
        clear_parse();
        got = 1'b1;
        k.key_kind = tekd_pkg::K_ESC;
      end else begin
        if (seq_cnt == '0) first_prm = b;
        seq_cnt = seq_cnt + tekd_pkg::CNT_W'(1);
        if (want_digit) begin
          want_digit = 1'b0;
          if (b >= tekd_pkg::CH_0 && b <= tekd_pkg::CH_9)
            mod_digit = 4'(b - tekd_pkg::CH_0);
        end else if (b == tekd_pkg::CH_SEMI && !semi_seen) begin
          semi_seen  = 1'b1;
          want_digit = 1'b1;
        end
        if (ends_seq(b)) begin
          sh   = semi_seen && mod_digit == SHIFT_MOD;
          kind = tekd_pkg::K_ESC;
          case (b)
            tekd_pkg::CH_UA: kind = tekd_pkg::K_UP;
            tekd_pkg::CH_UB: kind = tekd_pkg::K_DOWN;
            tekd_pkg::CH_UC: kind = tekd_pkg::K_RIGHT;
            tekd_pkg::CH_UD: kind = tekd_pkg::K_LEFT;
            tekd_pkg::CH_UH: kind = tekd_pkg::K_HOME;
            tekd_pkg::CH_UF: kind = tekd_pkg::K_END;
            tekd_pkg::CH_TILDE: begin
              sh = 1'b0;
              case (first_prm)
                tekd_pkg::CH_1: kind = tekd_pkg::K_HOME;
                tekd_pkg::CH_3: kind = tekd_pkg::K_DEL;
                tekd_pkg::CH_4: kind = tekd_pkg::K_END;
                tekd_pkg::CH_5: kind = tekd_pkg::K_PGUP;
                tekd_pkg::CH_6: kind = tekd_pkg::K_PGDN;
                default:        kind = tekd_pkg::K_ESC;
              endcase
            end
            default: sh = 1'b0;
          endcase
          clear_parse();
          got = 1'b1;
          k.key_kind = kind;
          k.shifted  = sh;
        end else if (seq_cnt >= tekd_pkg::SEQ_LIMIT) begin
          clear_parse();
          got = 1'b1;
          k.key_kind = tekd_pkg::K_ESC;
        end
      end
    end else begin
      if (w.action == tekd_pkg::ACT_IDLE) begin
        phase = tekd_pkg::PH_GROUND;
      end else if (b == tekd_pkg::CH_ESC) begin
        clear_parse();
        phase = tekd_pkg::PH_ESC;
      end else begin
        clear_parse();
        got = 1'b1;
        k.key_kind   = tekd_pkg::K_PLAIN;
        k.plain_byte = b;
      end
    end
  endtask

  // Present one word, hold it until taken, log its key, maybe pause after
  task automatic send_word(input tekd_pkg::byte_item_t w, input bit known,
                           input tekd_pkg::key_item_t typed);
    bit                  got;
    tekd_pkg::key_item_t k;
    byte_valid <= 1'b1;
    byte_item  <= w;
    do @(posedge clk); while (byte_stall);
    if (!(w.action == tekd_pkg::ACT_IDLE && phase != tekd_pkg::PH_ESC &&
          phase != tekd_pkg::PH_CSI)) sent_items++;
    decode_word(w, got, k);
    if (known) expected_keys.push_back(typed);
    else if (got) expected_keys.push_back(k);
    if (!calm && tx_odds != 0 && $urandom_range(0, tx_odds - 1) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Hold the byte side until every pending key word is out
  task automatic drain_keys();
    byte_valid <= 1'b0;
    do @(posedge clk); while (expected_keys.size() != 0);
  endtask

  // Send one random CSI sequence, sometimes cut short by idle
  task automatic send_csi();
    logic [7:0] seq[$];
    int         shape;
    int         cut;
    int         n;
    seq   = {tekd_pkg::CH_ESC, tekd_pkg::CH_LBRK};
    shape = $urandom_range(0, 9);
    if (shape < 4) begin
      if ($urandom_range(0, 1) == 1) begin
        seq.push_back(tekd_pkg::CH_1);
        seq.push_back(tekd_pkg::CH_SEMI);
        seq.push_back(mod_byte());
      end
      seq.push_back(CURSOR_FINALS[$urandom_range(0, 5)]);
    end else if (shape < 7) begin
      if ($urandom_range(0, 3) == 0)
        seq.push_back(tekd_pkg::CH_0 + 8'($urandom_range(0, 9)));
      else
        seq.push_back(TILDE_PARAMS[$urandom_range(0, 4)]);
      if ($urandom_range(0, 3) == 0) begin
        seq.push_back(tekd_pkg::CH_SEMI);
        seq.push_back(mod_byte());
      end
      seq.push_back(tekd_pkg::CH_TILDE);
    end else if (shape < 9) begin
      n = $urandom_range(0, 5);
      repeat (n) seq.push_back(($urandom_range(0, 2) == 0) ? tekd_pkg::CH_SEMI : mid_byte());
      case ($urandom_range(0, 2))
        0:       seq.push_back(8'($urandom_range(tekd_pkg::CH_UA, tekd_pkg::CH_UZ)));
        1:       seq.push_back(8'($urandom_range(tekd_pkg::CH_LA, tekd_pkg::CH_LZ)));
        default: seq.push_back(tekd_pkg::CH_TILDE);
      endcase
    end else begin
      // run to around the buffer limit, sometimes past it
      n = $urandom_range(int'(tekd_pkg::SEQ_LIMIT) - 2, int'(tekd_pkg::SEQ_LIMIT) + 2);
      repeat (n) seq.push_back(mid_byte());
      seq.push_back(CURSOR_FINALS[$urandom_range(0, 5)]);
    end
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(2, seq.size() - 1) : seq.size();
    for (int i = 0; i < cut; i++) send_word({tekd_pkg::ACT_BYTE, seq[i]}, 1'b0, NO_KEY);
    if (cut < seq.size()) send_word({tekd_pkg::ACT_IDLE, 8'($urandom)}, 1'b0, NO_KEY);
  endtask

  // Stall the key side in random bursts
  always @(posedge clk) begin
    if (rst || calm || rx_odds == 0) begin
      stall_left = 0;
      key_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      key_stall <= 1'b1;
    end else if ($urandom_range(0, rx_odds - 1) == 0) begin
      stall_left = $urandom_range(0, 15);
      key_stall <= 1'b1;
    end else begin
      key_stall <= 1'b0;
    end
  end

  // Compare each accepted key word with the oldest prediction
  always @(posedge clk) begin
    tekd_pkg::key_item_t want;
    if (!rst && key_valid && !key_stall) begin
      if (expected_keys.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_SHOWN)
          $display("%0t: unexpected key word kind=%0d shifted=%0d byte=%02h",
                   $realtime, key_item.key_kind, key_item.shifted, key_item.plain_byte);
      end else begin
        want = expected_keys.pop_front();
        if (key_item.key_kind !== want.key_kind || key_item.shifted !== want.shifted ||
            key_item.plain_byte !== want.plain_byte) begin
          bad_count++;
          if (bad_count <= MAX_SHOWN)
            $display("%0t: exp kind=%0d sh=%0d byte=%02h, got kind=%0d sh=%0d byte=%02h",
                     $realtime, want.key_kind, want.shifted, want.plain_byte,
                     key_item.key_kind, key_item.shifted, key_item.plain_byte);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int next_mix;
    int next_drain;
    clear_parse();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < PLAN_LEN; i++)
      send_word({PLAN[i].action, PLAN[i].data}, PLAN[i].known, PLAN[i].key);
    drain_keys();

    // random sequences and noise
    next_mix   = 0;
    next_drain = sent_items + 400;
    while (sent_items < TOTAL_ITEMS) begin
      if (sent_items >= next_mix) begin
        case ($urandom_range(0, 2))
          0:       tx_odds = 0;
          1:       tx_odds = 3;
          default: tx_odds = 8;
        endcase
        case ($urandom_range(0, 2))
          0:       rx_odds = 0;
          1:       rx_odds = 3;
          default: rx_odds = 8;
        endcase
        next_mix = sent_items + 150;
      end
      if (sent_items >= TOTAL_ITEMS - CALM_ITEMS) calm = 1'b1;
      if ($urandom_range(0, 9) < 7) begin
        send_csi();
      end else begin
        case ($urandom_range(0, 4))
          0, 1: send_word({tekd_pkg::ACT_BYTE, 8'($urandom)}, 1'b0, NO_KEY);
          2:    send_word({tekd_pkg::ACT_IDLE, 8'($urandom)}, 1'b0, NO_KEY);
          3: begin
            send_word({tekd_pkg::ACT_BYTE, tekd_pkg::CH_ESC}, 1'b0, NO_KEY);
            send_word({tekd_pkg::ACT_BYTE, 8'($urandom)}, 1'b0, NO_KEY);
          end
          default: begin
            send_word({tekd_pkg::ACT_BYTE, tekd_pkg::CH_ESC}, 1'b0, NO_KEY);
            send_word({tekd_pkg::ACT_IDLE, 8'($urandom)}, 1'b0, NO_KEY);
          end
        endcase
      end
      if (!calm && sent_items >= next_drain) begin
        drain_keys();
        next_drain = sent_items + 400;
      end
    end

    // let the pipeline empty
    byte_valid <= 1'b0;
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_count == 0 && expected_keys.size() == 0) begin
      $display("PASS terminal_escape_key_decoder");
    end else begin
      $display("FAIL terminal_escape_key_decoder");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL terminal_escape_key_decoder");
    $finish;
  end

endmodule
